FILE: sv/cgvc_pkg.sv
// Shared types and constants for the capped greedy vertex coloring unit.
// Transaction payload structs, field widths and the search result struct.
// No dependencies.
package cgvc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_CLASSES_DEF  = 64;

	localparam int VID_W   = 6;
	localparam int MASK_W  = 64;
	localparam int CLS_W   = 7;
	localparam int STORE_W = 6;

	typedef struct packed {
		logic [VID_W-1:0]  vertex_id;
		logic [MASK_W-1:0] neighbour_mask;
		logic              start_order;
	} in_item_t;

	typedef struct packed {
		logic [VID_W-1:0] vertex_id_out;
		logic [CLS_W-1:0] class_index;
		logic             in_branching_set;
	} out_item_t;

	typedef struct packed {
		logic             found;
		logic [CLS_W-1:0] class_idx;
	} srch_res_t;

endpackage

FILE: sv/cgvc_class_mem.sv
// Class store: one stored class per vertex, synchronous write and read.
// Read data is registered and appears in the cycle after the read request. Uses cgvc_pkg.
module cgvc_class_mem #(
	parameter int DEPTH = cgvc_pkg::MAX_VERTICES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [cgvc_pkg::STORE_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [cgvc_pkg::STORE_W-1:0] rd_data
);
	import cgvc_pkg::*;

	logic [STORE_W-1:0] mem_q [DEPTH];
	logic [STORE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/cgvc_free_search.sv
// First-free class search as a two-level registered tree.
// Groups of eight are encoded and registered, then the first group is picked.
// Uses cgvc_pkg.
module cgvc_free_search #(
	parameter int NUM_CLASSES = cgvc_pkg::MAX_CLASSES_DEF
) (
	input  logic                     clk,
	input  logic [NUM_CLASSES-1:0]   free_vec,
	output cgvc_pkg::srch_res_t      res
);
	import cgvc_pkg::*;

	localparam int GROUPS = (NUM_CLASSES + 7) / 8;
	localparam int PAD_W  = GROUPS * 8;

	logic [PAD_W-1:0]  padded;
	logic [GROUPS-1:0] any_c;
	logic [2:0]        first_c [GROUPS];
	logic [GROUPS-1:0] any_s1;
	logic [2:0]        first_s1 [GROUPS];

	assign padded = PAD_W'(free_vec);

	// Encode each group of eight on its own
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			any_c[g]   = |padded[g*8 +: 8];
			first_c[g] = '0;
			for (int b = 7; b >= 0; b--) begin
				if (padded[g*8 + b]) begin
					first_c[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s1 <= any_c;
		for (int g = 0; g < GROUPS; g++) begin
			first_s1[g] <= first_c[g];
		end
	end

	// Pick the lowest group holding a free class
	always_comb begin
		res.found     = 1'b0;
		res.class_idx = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				res.found     = 1'b1;
				res.class_idx = CLS_W'(g * 8) + {{(CLS_W-3){1'b0}}, first_s1[g]};
			end
		end
	end

endmodule

FILE: sv/capped_greedy_vertex_coloring_unit.sv
// Top level of the capped greedy vertex coloring unit: sequencer, classed
// vector, limit register and output register. Uses cgvc_pkg, cgvc_class_mem
// and cgvc_free_search.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+----------------------
//  in      | in_valid, in_ready, in_data     | to unit   | cgvc_pkg::in_item_t
//  out     | out_valid, out_ready, out_data  | from unit | cgvc_pkg::out_item_t
//  cfg     | cfg_valid, cfg_ready, cfg_data  | to unit   | class_limit, 7 bits
//
// An accepted vertex passes through the scan, drain, search and done states:
// the single read port of the class store delivers one stored class per cycle,
// the drain state takes in the last read, the search state runs the first-free
// search tree, and the done state writes back and loads the output register.
// One vertex is in work at a time; a new one is taken while the previous
// result waits in the output register. A stalled output holds the unit in
// its write-back cycle. Reset clears the classed vector, the limit and the
// control state; the class store itself needs no clearing pass.
module capped_greedy_vertex_coloring_unit #(
	parameter int MAX_VERTICES = cgvc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_CLASSES  = cgvc_pkg::MAX_CLASSES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cgvc_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cgvc_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cgvc_pkg::CLS_W-1:0] cfg_data
);
	import cgvc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_SRCH  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]              state_q;
	logic [CLS_W-1:0]        class_limit_q;
	logic [CLS_W-1:0]        lim_q;
	logic [VID_W-1:0]        vid_q;
	logic [MAX_VERTICES-1:0] mask_q;
	logic [MAX_VERTICES-1:0] classed_q;
	logic [MAX_CLASSES-1:0]  used_q;
	logic [VW-1:0]           idx_q;
	logic                    rd_vld_s1;
	logic                    hit_s1;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	logic                    in_fire;
	logic                    rd_en;
	logic [STORE_W-1:0]      rd_data;
	logic [MAX_CLASSES-1:0]  free_vec;
	srch_res_t               srch_res;
	logic                    out_free;
	logic                    finish;
	logic                    store_ok;
	logic [CLS_W-1:0]        eff_limit;
	logic [CLS_W-1:0]        cls_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Saturate the configured limit to the class count
	assign eff_limit = (class_limit_q > CLS_W'(MAX_CLASSES)) ? CLS_W'(MAX_CLASSES)
	                                                         : class_limit_q;

	assign rd_en = (state_q == ST_SCAN);

	cgvc_class_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (VW)
	) u_class_mem (
		.clk     (clk),
		.wr_en   (finish && store_ok),
		.wr_addr (vid_q[VW-1:0]),
		.wr_data (srch_res.class_idx[STORE_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// A class is free when no classed neighbour holds it and it lies below the limit
	always_comb begin
		for (int c = 0; c < MAX_CLASSES; c++) begin
			free_vec[c] = !used_q[c] && (CLS_W'(c) < lim_q);
		end
	end

	cgvc_free_search #(
		.NUM_CLASSES (MAX_CLASSES)
	) u_free_search (
		.clk      (clk),
		.free_vec (free_vec),
		.res      (srch_res)
	);

	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign store_ok = srch_res.found && ({1'b0, vid_q} < CLS_W'(MAX_VERTICES));
	assign cls_out  = srch_res.found ? srch_res.class_idx : lim_q;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			class_limit_q <= cfg_data;
		end
	end

	// Sequencer: scan every stored class, search, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == VW'(MAX_VERTICES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Classed vector: drop all on a start flag, mark on write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classed_q <= '0;
		end else if (in_fire && in_data.start_order) begin
			classed_q <= '0;
		end else if (finish && store_ok) begin
			classed_q[vid_q[VW-1:0]] <= 1'b1;
		end
	end

	// Item payload and used-class collection
	always_ff @(posedge clk) begin
		if (in_fire) begin
			vid_q  <= in_data.vertex_id;
			mask_q <= in_data.neighbour_mask[MAX_VERTICES-1:0];
			lim_q  <= eff_limit;
			used_q <= '0;
		end else if (rd_vld_s1 && hit_s1) begin
			for (int c = 0; c < MAX_CLASSES; c++) begin
				if (rd_data == STORE_W'(c)) begin
					used_q[c] <= 1'b1;
				end
			end
		end
		hit_s1 <= mask_q[idx_q] && classed_q[idx_q];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q.vertex_id_out    <= vid_q;
			out_data_q.class_index      <= cls_out;
			out_data_q.in_branching_set <= !srch_res.found;
		end
	end

endmodule

FILE: sv/cgvc_checker.sv
// Port-level checker for the capped greedy vertex coloring unit, with its bind.
// Watches the transaction channels only. Uses cgvc_pkg.
module cgvc_checker #(
	parameter int MAX_CLASSES = cgvc_pkg::MAX_CLASSES_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input cgvc_pkg::out_item_t  out_data
);
	import cgvc_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Busy right after taking a vertex
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a vertex is in work");

	// No result can appear in the cycle after a vertex is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	// A class below the limit is always below the class count
	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_branching_set |->
			out_data.class_index < CLS_W'(MAX_CLASSES))
		else $error("assigned class out of range");

endmodule

bind capped_greedy_vertex_coloring_unit cgvc_checker #(
	.MAX_CLASSES (MAX_CLASSES)
) u_cgvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
